// ===== rtl/core/rct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg: shared types and constants
// Command, result and sequencer types for the rolling code table.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam int ADDR_W              = 32;
    localparam int CODE_W              = 16;
    localparam int FILL_W              = 5;

    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_SET    = 2'd1,
        ACT_FORGET = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [ADDR_W-1:0]   rmt_addr;
        logic [CODE_W-1:0]   code_in;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic [CODE_W-1:0]   code_out;
        logic [FILL_W-1:0]   fill_count;
    } t_result;

endpackage

// ===== rtl/core/rct_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_cmd_if: command channel
// Valid/ready channel carrying one table command per transaction.
// ----------------------------------------------------------------------------
interface rct_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [rct_pkg::ADDR_W-1:0] rmt_addr;
    logic [rct_pkg::CODE_W-1:0] code_in;

    modport source (output valid, output action, output rmt_addr, output code_in,
                    input ready);
    modport sink   (input valid, input action, input rmt_addr, input code_in,
                    output ready);
endinterface

// ===== rtl/core/rct_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_res_if: result channel
// Valid/ready channel carrying one command result per transaction.
// ----------------------------------------------------------------------------
interface rct_res_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [rct_pkg::CODE_W-1:0] code_out;
    logic [rct_pkg::FILL_W-1:0] fill_count;

    modport source (output valid, output status, output code_out, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input code_out, input fill_count,
                    output ready);
endinterface

// ===== rtl/core/rct_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/rct_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_seq: table sequencer
// Scans the entry RAM one entry per cycle, updates or appends on set,
// shifts later entries down on forget, and holds the fill count.
// ----------------------------------------------------------------------------
module rct_seq #(
    parameter int MAX_ENTRIES = rct_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    // command side
    input  logic                                                i_cmd_valid,
    input  rct_pkg::t_cmd                                       i_cmd,
    output logic                                                o_cmd_ready,
    // result side
    output logic                                                o_res_valid,
    output rct_pkg::t_result                                    o_res,
    input  logic                                                i_res_ready,
    // entry RAM
    output logic                                                o_we,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] o_waddr,
    output logic [rct_pkg::ADDR_W+rct_pkg::CODE_W-1:0]          o_wdata,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] o_raddr,
    input  logic [rct_pkg::ADDR_W+rct_pkg::CODE_W-1:0]          i_rdata
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = rct_pkg::ADDR_W + rct_pkg::CODE_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    rct_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [IDX_W-1:0] r_idx,   n_idx;
    rct_pkg::t_cmd    r_cmd,   n_cmd;
    rct_pkg::t_result r_res,   n_res;

    logic [CNT_W-1:0] w_idx_p1;
    logic [CNT_W-1:0] w_idx_p2;
    logic             w_hit;
    logic             w_more;
    logic             w_shift_more;

    assign w_idx_p1     = CNT_W'(r_idx) + CNT_W'(1);
    assign w_idx_p2     = w_idx_p1 + CNT_W'(1);
    assign w_hit        = (i_rdata[ENT_W-1:rct_pkg::CODE_W] == r_cmd.rmt_addr);
    assign w_more       = (w_idx_p1 < r_cnt);
    assign w_shift_more = (w_idx_p2 < r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rct_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.action == rct_pkg::ACT_CLEAR || r_cnt == '0) begin
                        n_state = rct_pkg::ST_DONE;
                    end else begin
                        n_state = rct_pkg::ST_SCAN;
                    end
                end
            end
            rct_pkg::ST_SCAN: begin
                if (w_hit) begin
                    if (r_cmd.action == rct_pkg::ACT_FORGET && w_more) begin
                        n_state = rct_pkg::ST_SHIFT;
                    end else begin
                        n_state = rct_pkg::ST_DONE;
                    end
                end else if (!w_more) begin
                    n_state = rct_pkg::ST_DONE;
                end
            end
            rct_pkg::ST_SHIFT: begin
                if (!w_shift_more) begin
                    n_state = rct_pkg::ST_DONE;
                end
            end
            rct_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = rct_pkg::ST_IDLE;
                end
            end
            default: n_state = rct_pkg::ST_IDLE;
        endcase
    end

    // count, index and result
    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_cmd = r_cmd;
        n_res = r_res;
        case (r_state)
            rct_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd          = i_cmd;
                    n_idx          = '0;
                    n_res.status   = rct_pkg::STAT_OK;
                    n_res.code_out = '0;
                    if (i_cmd.action == rct_pkg::ACT_CLEAR) begin
                        n_cnt = '0;
                    end else if (r_cnt == '0) begin
                        if (i_cmd.action == rct_pkg::ACT_SET) begin
                            n_cnt = CNT_W'(1);
                        end else begin
                            n_res.status = rct_pkg::STAT_NOT_FOUND;
                        end
                    end
                end
            end
            rct_pkg::ST_SCAN: begin
                if (w_hit) begin
                    case (r_cmd.action)
                        rct_pkg::ACT_GET: begin
                            n_res.code_out = i_rdata[rct_pkg::CODE_W-1:0];
                        end
                        rct_pkg::ACT_FORGET: begin
                            if (!w_more) begin
                                n_cnt = r_cnt - CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end else if (w_more) begin
                    n_idx = IDX_W'(w_idx_p1);
                end else if (r_cmd.action == rct_pkg::ACT_SET) begin
                    if (r_cnt >= MAX_CNT) begin
                        n_res.status = rct_pkg::STAT_FULL;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else begin
                    n_res.status = rct_pkg::STAT_NOT_FOUND;
                end
            end
            rct_pkg::ST_SHIFT: begin
                n_idx = IDX_W'(w_idx_p1);
                if (!w_shift_more) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: ;
        endcase
        if (r_state != rct_pkg::ST_DONE) begin
            n_res.fill_count = rct_pkg::FILL_W'(n_cnt);
        end
    end

    // handshake and RAM control
    always_comb begin
        o_cmd_ready = (r_state == rct_pkg::ST_IDLE);
        o_res_valid = (r_state == rct_pkg::ST_DONE);
        o_res       = r_res;
        o_we        = 1'b0;
        o_waddr     = r_idx;
        o_wdata     = {r_cmd.rmt_addr, r_cmd.code_in};
        o_raddr     = r_idx;
        case (r_state)
            rct_pkg::ST_IDLE: begin
                o_raddr = '0;
                if (i_cmd_valid && i_cmd.action == rct_pkg::ACT_SET && r_cnt == '0) begin
                    o_we    = 1'b1;
                    o_waddr = '0;
                    o_wdata = {i_cmd.rmt_addr, i_cmd.code_in};
                end
            end
            rct_pkg::ST_SCAN: begin
                o_raddr = IDX_W'(w_idx_p1);
                if (r_cmd.action == rct_pkg::ACT_SET) begin
                    if (w_hit) begin
                        o_we = 1'b1;
                    end else if (!w_more && r_cnt < MAX_CNT) begin
                        o_we    = 1'b1;
                        o_waddr = IDX_W'(r_cnt);
                    end
                end
            end
            rct_pkg::ST_SHIFT: begin
                o_raddr = IDX_W'(w_idx_p2);
                o_we    = 1'b1;
                o_wdata = i_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rct_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_res <= n_res;
    end
endmodule

// ===== rtl/core/rolling_code_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_code_table: remote address / rolling code table
// Up to MAX_ENTRIES pairs of 32-bit address and 16-bit code in one RAM,
// with get, set, forget and clear commands.
// ----------------------------------------------------------------------------
// Clear, and any command on an empty table, go from idle straight to done.
//   Get/set: scan the entries in order until a hit or the end, one RAM read per cycle.
//   Forget: additionally moves each later entry down one slot.
// One command at a time: no new command is taken until the sequencer has handed off its result.
// Reset clears the fill count, the sequencer state and the output valid; RAM contents are left as they are.
// ----------------------------------------------------------------------------
module rolling_code_table #(
    parameter int MAX_ENTRIES = rct_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rct_cmd_if.sink   i_cmd,
    rct_res_if.source o_res
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_W = rct_pkg::ADDR_W + rct_pkg::CODE_W;

    rct_pkg::t_cmd    w_cmd;
    rct_pkg::t_result w_res;
    logic             w_res_valid;
    logic             w_res_ready;

    // entry RAM port
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;
    logic [ENT_W-1:0] w_rdata;

    // output register: decouples the sequencer from the result channel
    logic             r_out_valid;
    rct_pkg::t_result r_out;

    assign w_cmd.action   = rct_pkg::t_action'(i_cmd.action);
    assign w_cmd.rmt_addr = i_cmd.rmt_addr;
    assign w_cmd.code_in  = i_cmd.code_in;

    rct_seq #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (i_cmd.ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    // each word: address in the upper bits, code in the lower bits
    rct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result slot is free when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out.status;
    assign o_res.code_out   = r_out.code_out;
    assign o_res.fill_count = r_out.fill_count;

    // a code is only ever returned by a successful get
    a_code_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != rct_pkg::STAT_OK) |-> (o_res.code_out == '0))
        else $error("nonzero code with error status");

    // full status only when the table is at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == rct_pkg::STAT_FULL)
            |-> (o_res.fill_count == rct_pkg::FILL_W'(MAX_ENTRIES)))
        else $error("full status below capacity");

    // a finished result always lands in the output register
    a_res_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> r_out_valid)
        else $error("result lost between sequencer and output");
endmodule

// ===== tb/rolling_code_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_code_table_test: self-checking bench for the rolling code table
// Runs a short directed sequence (empty table, extreme addresses and codes,
// fill to full, insert on full, forget at head/middle/tail, clear), then
// several hundred random commands drawn mostly from a small address pool so
// that lookups hit, the table fills and drains. Every result is checked field
// by field against a typed value or a behavioral copy of the table kept in
// the bench. Both channels idle at random, save in calm stretches.
// ----------------------------------------------------------------------------
module rolling_code_table_test;
    import rct_pkg::*;

    localparam int TBL_DEPTH  = DEFAULT_MAX_ENTRIES;
    localparam int RAND_CMDS  = 400;
    localparam int POOL_SIZE  = 24;     // more addresses than slots, so full is reached
    localparam int MAX_IDLE   = 18;
    localparam int DRAIN_WAIT = 2 * TBL_DEPTH + 8;   // worst-case command latency plus margin

    // One row of the directed plan. A row with reps > 1 is repeated with the
    // address incremented and the code xor'ed by the repeat index. Rows with
    // known = 1 carry a hand-typed result; the others use the table model.
    typedef struct {
        t_action             act;
        logic [ADDR_W-1:0]   addr;
        logic [CODE_W-1:0]   code;
        int                  reps;
        bit                  known;
        t_status             st;
        logic [CODE_W-1:0]   cout;
        logic [FILL_W-1:0]   fill;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rct_cmd_if cmd_ch ();
    rct_res_if res_ch ();

    rolling_code_table #(
        .MAX_ENTRIES (TBL_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model: own copy of the pairs and the fill count
    // ------------------------------------------------------------------------
    logic [ADDR_W-1:0] tbl_addr [TBL_DEPTH];
    logic [CODE_W-1:0] tbl_code [TBL_DEPTH];
    int                tbl_fill;

    t_result pending_results [$];      // results still owed by the block
    int      mismatches;
    int      results_seen;
    int      cmds_sent;
    int      act_count    [4];
    int      status_count [3];
    int      peak_fill;

    // Apply one command to the model and return the result it must produce.
    // Only the first matching pair counts; pairs at or above the fill count
    // are never looked at.
    function automatic t_result table_apply(input t_cmd c);
        t_result r;
        int      hit;
        hit          = -1;
        r.status     = STAT_OK;
        r.code_out   = '0;
        for (int i = 0; i < tbl_fill; i++) begin
            if (hit < 0 && tbl_addr[i] == c.rmt_addr) begin
                hit = i;
            end
        end
        case (c.action)
            ACT_GET: begin
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.code_out = tbl_code[hit];
                end
            end
            ACT_SET: begin
                if (hit >= 0) begin
                    tbl_code[hit] = c.code_in;       // update wins even when full
                end else if (tbl_fill >= TBL_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_addr[tbl_fill] = c.rmt_addr;
                    tbl_code[tbl_fill] = c.code_in;
                    tbl_fill++;
                end
            end
            ACT_FORGET: begin
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    // close the gap: every later pair moves down one slot
                    for (int i = hit; i < tbl_fill - 1; i++) begin
                        tbl_addr[i] = tbl_addr[i + 1];
                        tbl_code[i] = tbl_code[i + 1];
                    end
                    tbl_fill--;
                end
            end
            default: begin
                tbl_fill = 0;
            end
        endcase
        r.fill_count = FILL_W'(tbl_fill);
        if (tbl_fill > peak_fill) begin
            peak_fill = tbl_fill;
        end
        return r;
    endfunction

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        $display("%0t ns  mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Command side: hold valid and payload until the block takes the
    // transaction, then book the expected result. Valid is left high so a
    // back-to-back transaction never lowers and raises it in one step.
    // ------------------------------------------------------------------------
    task automatic issue(input t_cmd c, input bit known, input t_result typed);
        t_result modeled;
        cmd_ch.valid    <= 1'b1;
        cmd_ch.action   <= c.action;
        cmd_ch.rmt_addr <= c.rmt_addr;
        cmd_ch.code_in  <= c.code_in;
        do @(posedge i_clk); while (!cmd_ch.ready);
        modeled = table_apply(c);
        pending_results.push_back(known ? typed : modeled);
        act_count[c.action]++;
        cmds_sent++;
    endtask

    // Idle gap after a transaction; calm stretches never idle.
    task automatic sender_gap(input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready back-pressure, stall drawn per transaction
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            // every fourth block of 30 results sees no stalls at all
            stall = ((results_seen / 30) % 4 == 0) ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Result checker: compare against the oldest expectation
    t_result owed;
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report("result with nothing pending",
                       0, 32'({res_ch.status, res_ch.code_out, res_ch.fill_count}));
            end else begin
                owed = pending_results.pop_front();
                status_count[owed.status]++;
                if (res_ch.status !== owed.status) begin
                    report("status", 32'(owed.status), 32'(res_ch.status));
                end
                if (res_ch.code_out !== owed.code_out) begin
                    report("code_out", 32'(owed.code_out), 32'(res_ch.code_out));
                end
                if (res_ch.fill_count !== owed.fill_count) begin
                    report("fill_count", 32'(owed.fill_count), 32'(res_ch.fill_count));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_plan_row directed_plan [23];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    initial begin
        t_cmd    c;
        t_result typed;
        int      pick;
        int      set_weight;

        cmd_ch.valid    <= 1'b0;
        cmd_ch.action   <= ACT_GET;
        cmd_ch.rmt_addr <= '0;
        cmd_ch.code_in  <= '0;
        i_rst_n         <= 1'b0;
        tbl_fill     = 0;
        mismatches   = 0;
        results_seen = 0;
        cmds_sent    = 0;
        peak_fill    = 0;
        act_count    = '{0, 0, 0, 0};
        status_count = '{0, 0, 0};

        // After row 10 the table holds: 0, FFFFFFFF, AAAAAAAA..AAAAAAB7 (full)
        directed_plan = '{
            '{ACT_GET,    32'h0000_0000, 16'hBEEF,  1, 1'b1, STAT_NOT_FOUND, 16'h0000,  5'd0},
            '{ACT_FORGET, 32'h0000_0000, 16'h0000,  1, 1'b1, STAT_NOT_FOUND, 16'h0000,  5'd0},
            '{ACT_CLEAR,  32'hFFFF_FFFF, 16'hFFFF,  1, 1'b1, STAT_OK,        16'h0000,  5'd0},
            '{ACT_SET,    32'h0000_0000, 16'h0000,  1, 1'b1, STAT_OK,        16'h0000,  5'd1},
            '{ACT_SET,    32'hFFFF_FFFF, 16'hFFFF,  1, 1'b1, STAT_OK,        16'h0000,  5'd2},
            '{ACT_GET,    32'hFFFF_FFFF, 16'h0000,  1, 1'b1, STAT_OK,        16'hFFFF,  5'd2},
            '{ACT_GET,    32'h0000_0000, 16'hFFFF,  1, 1'b1, STAT_OK,        16'h0000,  5'd2},
            '{ACT_SET,    32'h0000_0000, 16'h5555,  1, 1'b1, STAT_OK,        16'h0000,  5'd2},
            '{ACT_GET,    32'h1234_5678, 16'h0000,  1, 1'b1, STAT_NOT_FOUND, 16'h0000,  5'd2},
            '{ACT_SET,    32'hAAAA_AAAA, 16'h0F0F, 14, 1'b0, STAT_OK,        16'h0000,  5'd0},
            '{ACT_SET,    32'h5555_5555, 16'h1234,  1, 1'b1, STAT_FULL,      16'h0000,  5'd16},
            '{ACT_SET,    32'h0000_0000, 16'hFFFF,  1, 1'b1, STAT_OK,        16'h0000,  5'd16},
            '{ACT_GET,    32'h0000_0000, 16'h0000,  1, 1'b1, STAT_OK,        16'hFFFF,  5'd16},
            '{ACT_FORGET, 32'hFFFF_FFFF, 16'h0000,  1, 1'b1, STAT_OK,        16'h0000,  5'd15},
            '{ACT_GET,    32'hAAAA_AAB0, 16'h0000,  1, 1'b0, STAT_OK,        16'h0000,  5'd0},
            '{ACT_FORGET, 32'h0000_0000, 16'h0000,  1, 1'b1, STAT_OK,        16'h0000,  5'd14},
            '{ACT_FORGET, 32'hAAAA_AAB7, 16'h0000,  1, 1'b1, STAT_OK,        16'h0000,  5'd13},
            '{ACT_FORGET, 32'hAAAA_AAB7, 16'h0000,  1, 1'b1, STAT_NOT_FOUND, 16'h0000,  5'd13},
            '{ACT_SET,    32'h5555_5555, 16'h1234,  1, 1'b1, STAT_OK,        16'h0000,  5'd14},
            '{ACT_GET,    32'h5555_5555, 16'h0000,  1, 1'b1, STAT_OK,        16'h1234,  5'd14},
            '{ACT_CLEAR,  32'h0000_0000, 16'h0000,  1, 1'b1, STAT_OK,        16'h0000,  5'd0},
            '{ACT_GET,    32'h5555_5555, 16'h0000,  1, 1'b1, STAT_NOT_FOUND, 16'h0000,  5'd0},
            '{ACT_CLEAR,  32'h0000_0000, 16'h0000,  1, 1'b1, STAT_OK,        16'h0000,  5'd0}
        };

        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = $urandom;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        foreach (directed_plan[r]) begin
            for (int k = 0; k < directed_plan[r].reps; k++) begin
                c.action         = directed_plan[r].act;
                c.rmt_addr       = directed_plan[r].addr + ADDR_W'(k);
                c.code_in        = directed_plan[r].code ^ CODE_W'(k);
                typed.status     = directed_plan[r].st;
                typed.code_out   = directed_plan[r].cout;
                typed.fill_count = directed_plan[r].fill;
                issue(c, directed_plan[r].known, typed);
                sender_gap(r % 5 == 0);
            end
        end

        // Hold off until the block has answered everything so far
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);

        // Random part: alternating fill-heavy and drain-heavy blocks of 50,
        // addresses mostly from the pool so lookups and updates hit.
        for (int n = 0; n < RAND_CMDS; n++) begin
            set_weight = ((n / 50) % 2 == 0) ? 62 : 35;
            pick       = $urandom_range(0, 99);
            if (pick < set_weight) begin
                c.action = ACT_SET;
            end else if (pick < set_weight + (98 - set_weight) / 2) begin
                c.action = ACT_GET;
            end else if (pick < 98) begin
                c.action = ACT_FORGET;
            end else begin
                c.action = ACT_CLEAR;
            end
            c.rmt_addr = ($urandom_range(0, 9) < 8) ?
                         addr_pool[$urandom_range(0, POOL_SIZE - 1)] : ADDR_W'($urandom);
            c.code_in  = CODE_W'($urandom);
            typed      = '0;
            issue(c, 1'b0, typed);

            if (n == RAND_CMDS / 2) begin
                // let the block go fully quiet mid-run
                cmd_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end else begin
                sender_gap((n / 30) % 4 == 2);
            end
        end

        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d commands (get %0d, set %0d, forget %0d, clear %0d), %0d results.",
                 cmds_sent, act_count[ACT_GET], act_count[ACT_SET],
                 act_count[ACT_FORGET], act_count[ACT_CLEAR], results_seen);
        $display("Status ok %0d, not found %0d, full %0d; highest fill %0d; %0d mismatches.",
                 status_count[STAT_OK], status_count[STAT_NOT_FOUND],
                 status_count[STAT_FULL], peak_fill, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** rolling_code_table: PASSED **");
        end else begin
            $display("** rolling_code_table: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("** rolling_code_table: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rct_pkg.sv
rtl/core/rct_cmd_if.sv
rtl/core/rct_res_if.sv
rtl/core/rct_ram.sv
rtl/core/rct_seq.sv
rtl/core/rolling_code_table.sv
tb/rolling_code_table_test.sv
